// ----- rtl/amrc_pkg.sv -----
// Package for the annulus membership block: widths, register codes, payload types.
`timescale 1ns / 1ps
package amrc_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTRE_X = 4'd0,
        REG_CENTRE_Y = 4'd1,
        REG_CENTRE_Z = 4'd2,
        REG_AXIS_X   = 4'd3,
        REG_AXIS_Y   = 4'd4,
        REG_AXIS_Z   = 4'd5,
        REG_INNER    = 4'd6,
        REG_OUTER    = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] cell_index;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic [31:0] index_out;
        logic        inside_res;
        logic [16:0] sigma;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;
endpackage

// ----- rtl/amrc_if.sv -----
// Valid/ready channel interface carrying one payload item.
`timescale 1ns / 1ps
interface amrc_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/amrc_div.sv -----
// Pipelined restoring divider: quotient of (num << 16) / den, one bit per stage.
`timescale 1ns / 1ps
module amrc_div #(
    parameter int QW = 17,
    parameter int DW = 32,
    parameter int SW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);
    // quotient saturates at 2^17 - 1, so the top quotient bit means "at least 1.0"
    // and remainder starts as num << 16 with den scaled by 2^(QW-1)
    localparam int RW = DW + QW;
    logic          r_v    [QW+1];
    logic [RW-1:0] r_rem  [QW+1];
    logic [RW-1:0] r_den  [QW+1];
    logic [QW-1:0] r_q    [QW+1];
    logic [SW-1:0] r_side [QW+1];

    always_comb begin
        r_v[0]    = i_valid;
        r_rem[0]  = {{QW{1'b0}}, i_num} << (QW - 1);
        r_den[0]  = {i_den, {QW{1'b0}}} >> 1;
        r_q[0]    = '0;
        r_side[0] = i_side;
    end

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [RW-1:0] n_rem;
        logic          n_bit;
        always_comb begin
            n_bit = r_rem[g] >= (r_den[g] >> 0);
            n_rem = n_bit ? r_rem[g] - r_den[g] : r_rem[g];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_rem[g+1]  <= n_rem;
                r_den[g+1]  <= r_den[g] >> 1;
                r_q[g+1]    <= {r_q[g][QW-2:0], n_bit};
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quot  = r_q[QW];
    assign o_side  = r_side[QW];
endmodule

// ----- rtl/amrc_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module amrc_sqrt #(
    parameter int VW = 64,
    parameter int SW = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [VW-1:0]   i_val,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [VW/2-1:0] o_root,
    output logic [SW-1:0]   o_side
);
    localparam int N = VW / 2;
    logic          r_v    [N+1];
    logic [VW-1:0] r_val  [N+1];
    logic [VW-1:0] r_root [N+1];
    logic [SW-1:0] r_side [N+1];

    always_comb begin
        r_v[0]    = i_valid;
        r_val[0]  = i_val;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    // bit-pair stage: try r + b with b = 4^(N-1-g)
    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic [VW-1:0] B = {{(VW-1){1'b0}}, 1'b1} << (2 * (N - 1 - g));
        logic [VW-1:0] n_val, n_root, n_try;
        always_comb begin
            n_try = r_root[g] + B;
            if (r_val[g] >= n_try) begin
                n_val  = r_val[g] - n_try;
                n_root = (r_root[g] >> 1) + B;
            end else begin
                n_val  = r_val[g];
                n_root = r_root[g] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_val[g+1]  <= n_val;
                r_root[g+1] <= n_root;
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_root  = r_root[N][N-1:0];
    assign o_side  = r_side[N];
endmodule

// ----- rtl/annulus_membership_radial_coord.sv -----
// Top level: annulus membership and normalised radial coordinate pipeline.
//
//   channel   dir  payload
//   i_cfg     in   register index, write data
//   i_in      in   cell_index, point_x/y/z
//   o_out     out  index_out, inside_res, sigma
//
// One item enters per cycle while the output is not stalled; an item passes through
// the seven arithmetic stages, the bit-per-stage square root, the divider operand
// register, the bit-per-stage divider and the output register.
// Reset is synchronous; it clears the valid bits and sets the configuration registers to their reset values.
// A stall on the output freezes the whole pipeline; the output register is
// still loaded when empty, so nothing is lost or repeated.
`timescale 1ns / 1ps
module annulus_membership_radial_coord #(
    parameter int COORD_BITS = amrc_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    amrc_if.sink   i_cfg,
    amrc_if.sink   i_in,
    amrc_if.source o_out
);
    localparam int CB = (COORD_BITS < 32) ? COORD_BITS : 32;

    // configuration registers
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic signed [15:0] r_ax, r_ay, r_az;
    logic [30:0]        r_inner, r_outer;
    amrc_pkg::t_cfg_item w_cfg;
    assign w_cfg       = i_cfg.data;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_cz <= '0;
            r_ax <= '0; r_ay <= '0; r_az <= 16'sd16384;
            r_inner <= '0; r_outer <= 31'd65536;
        end else if (i_cfg.valid) begin
            unique case (w_cfg.index)
                amrc_pkg::REG_CENTRE_X: r_cx <= w_cfg.data;
                amrc_pkg::REG_CENTRE_Y: r_cy <= w_cfg.data;
                amrc_pkg::REG_CENTRE_Z: r_cz <= w_cfg.data;
                amrc_pkg::REG_AXIS_X:   r_ax <= w_cfg.data[15:0];
                amrc_pkg::REG_AXIS_Y:   r_ay <= w_cfg.data[15:0];
                amrc_pkg::REG_AXIS_Z:   r_az <= w_cfg.data[15:0];
                amrc_pkg::REG_INNER:    r_inner <= w_cfg.data[30:0];
                amrc_pkg::REG_OUTER:    r_outer <= w_cfg.data[30:0];
                default: ;
            endcase
        end
    end

    // sign-extend the low COORD_BITS bits of a coordinate; wider formats see
    // only the 32 carried bits, so the value reads as non-negative
    function automatic logic signed [33:0] coord(input logic [31:0] v);
        logic [31:0] m;
        m = v << (32 - CB);
        if (COORD_BITS > 32) return {2'b00, v};
        return 34'(signed'(m) >>> (32 - CB));
    endfunction

    // round half away from zero by 2^14
    function automatic logic signed [63:0] rnd14(input logic signed [63:0] x);
        logic [63:0] mag;
        mag = x[63] ? 64'(-x) : 64'(x);
        mag = (mag + 64'd8192) >> 14;
        return x[63] ? -signed'(mag) : signed'(mag);
    endfunction

    amrc_pkg::t_out_item r_out;
    logic r_out_v;
    logic w_en;
    assign w_en       = !r_out_v || o_out.ready;
    assign i_in.ready = w_en;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    amrc_pkg::t_in_item w_in;
    assign w_in = i_in.data;

    // stage 1: differences
    logic               r1_v;
    logic [31:0]        r1_idx;
    logic signed [33:0] r1_d [3];
    // stage 2: dot product terms
    logic               r2_v;
    logic [31:0]        r2_idx;
    logic signed [33:0] r2_d [3];
    logic signed [49:0] r2_p [3];
    // stage 3: t
    logic               r3_v;
    logic [31:0]        r3_idx;
    logic signed [33:0] r3_d [3];
    logic signed [51:0] r3_t;
    // stage 4: t * a
    logic               r4_v;
    logic [31:0]        r4_idx;
    logic signed [33:0] r4_d [3];
    logic signed [63:0] r4_ta [3];
    // stage 5: q and far
    logic               r5_v;
    logic [31:0]        r5_idx;
    logic [31:0]        r5_m [3];
    logic               r5_far;
    // stage 6: squares
    logic               r6_v;
    logic [31:0]        r6_idx;
    logic [63:0]        r6_s [3];
    logic               r6_far;
    // stage 7: sum
    logic               r7_v;
    logic [63:0]        r7_sum;
    logic [32:0]        r7_side;

    logic signed [15:0] w_a [3];
    assign w_a[0] = r_ax;
    assign w_a[1] = r_ay;
    assign w_a[2] = r_az;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0;
            r4_v <= 1'b0; r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in.valid; r2_v <= r1_v; r3_v <= r2_v;
            r4_v <= r3_v; r5_v <= r4_v; r6_v <= r5_v; r7_v <= r6_v;
        end
        if (w_en) begin
            r1_idx  <= w_in.cell_index;
            r1_d[0] <= coord(w_in.point_x) - coord(r_cx);
            r1_d[1] <= coord(w_in.point_y) - coord(r_cy);
            r1_d[2] <= coord(w_in.point_z) - coord(r_cz);
            r2_idx <= r1_idx;
            r2_d   <= r1_d;
            for (int i = 0; i < 3; i++) r2_p[i] <= r1_d[i] * w_a[i];
            r3_idx <= r2_idx;
            r3_d   <= r2_d;
            r3_t   <= 52'(rnd14(64'(r2_p[0]) + 64'(r2_p[1]) + 64'(r2_p[2])));
            r4_idx <= r3_idx;
            r4_d   <= r3_d;
            for (int i = 0; i < 3; i++) r4_ta[i] <= 64'(r3_t) * 64'(w_a[i]);
            r5_idx <= r4_idx;
            begin
                logic signed [63:0] q;
                logic f;
                f = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    q = 64'(r4_d[i]) - rnd14(r4_ta[i]);
                    if (q >= 64'sh80000000 || q <= -64'sh80000000) f = 1'b1;
                    r5_m[i] <= q[63] ? 32'(-q) : q[31:0];
                end
                r5_far <= f;
            end
            r6_idx <= r5_idx;
            r6_far <= r5_far;
            for (int i = 0; i < 3; i++) r6_s[i] <= r5_m[i] * r5_m[i];
            r7_sum  <= r6_s[0] + r6_s[1] + r6_s[2];
            r7_side <= {r6_far, r6_idx};
        end
    end

    // square root
    logic        w_sq_v;
    logic [31:0] w_dist;
    logic [32:0] w_sq_side;
    amrc_sqrt #(.VW(64), .SW(33)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r7_v), .i_val(r7_sum), .i_side(r7_side),
        .o_valid(w_sq_v), .o_root(w_dist), .o_side(w_sq_side)
    );

    // membership and divider operands
    logic        r8_v;
    logic [31:0] r8_num, r8_den;
    logic [33:0] r8_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (w_en) begin
            r8_v <= w_sq_v;
        end
        if (w_en) begin
            logic ins;
            ins = !w_sq_side[32] && w_dist >= 32'(r_inner) && w_dist <= 32'(r_outer);
            r8_num  <= w_dist - 32'(r_inner);
            r8_den  <= 32'(r_outer) - 32'(r_inner);
            r8_side <= {ins, ins && (r_outer > r_inner), w_sq_side[31:0]};
        end
    end

    logic        w_dv_v;
    logic [16:0] w_q;
    logic [33:0] w_dv_side;
    amrc_div #(.QW(17), .DW(32), .SW(34)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r8_v), .i_num(r8_num << 0), .i_den(r8_den), .i_side(r8_side),
        .o_valid(w_dv_v), .o_quot(w_q), .o_side(w_dv_side)
    );

    // output register; quotient bit 16 set means sigma >= 1.0, clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dv_v;
        end
        if (w_en) begin
            r_out.index_out  <= w_dv_side[31:0];
            r_out.inside_res <= w_dv_side[33];
            r_out.sigma      <= !w_dv_side[32] ? 17'd0 :
                                (w_q[16] ? 17'd65536 : w_q);
        end
    end
endmodule

// ----- tb/tb_annulus_membership_radial_coord.sv -----
// Testbench for the annulus membership block: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps
module tb_annulus_membership_radial_coord;
    localparam int             CYCLE_LIMIT = 1000000;
    localparam int             HOLD_CYCLES = 400;
    localparam int             DRAIN_WAIT  = 120;
    localparam logic [3:0]     REG_SPARE   = 4'd11;   // no register here

    logic i_clk;
    logic i_rst_n;

    amrc_if #(.T(amrc_pkg::t_cfg_item)) cfg_if ();
    amrc_if #(.T(amrc_pkg::t_in_item))  pt_if ();
    amrc_if #(.T(amrc_pkg::t_out_item)) ring_if ();

    annulus_membership_radial_coord i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (pt_if),
        .o_out   (ring_if)
    );

    // shadow of the zone registers
    logic [31:0] zc_x, zc_y, zc_z;
    logic [15:0] ax_x, ax_y, ax_z;
    logic [30:0] r_in, r_out;

    amrc_pkg::t_in_item  pending_pts[$];
    amrc_pkg::t_out_item ring_expect[$];
    int        err_count;
    int        cyc;
    bit        no_idle;
    int        hold_req, hold_seen, hold_left;
    int        tx_gap, rx_wait;
    bit        pt_acc, ring_acc;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint rnd_half(longint x, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (x >= 0) return (x + half) >>> s;
        return -((-x + half) >>> s);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // expected membership and radial coordinate for one point
    function automatic amrc_pkg::t_out_item predict_ring(amrc_pkg::t_in_item p);
        amrc_pkg::t_out_item res;
        longint          d[3], a[3], q[3], t, pv, cv;
        longint unsigned sum, rad, m, w, sig;
        bit              far, in_ring;
        pv = longint'($signed(p.point_x)); cv = longint'($signed(zc_x)); d[0] = pv - cv;
        pv = longint'($signed(p.point_y)); cv = longint'($signed(zc_y)); d[1] = pv - cv;
        pv = longint'($signed(p.point_z)); cv = longint'($signed(zc_z)); d[2] = pv - cv;
        a[0] = longint'($signed(ax_x));
        a[1] = longint'($signed(ax_y));
        a[2] = longint'($signed(ax_z));
        t = rnd_half(d[0] * a[0] + d[1] * a[1] + d[2] * a[2], 14);
        far = 1'b0;
        sum = 0;
        sig = 0;
        for (int i = 0; i < 3; i++) begin
            q[i] = d[i] - rnd_half(t * a[i], 14);
            if (q[i] >= (longint'(1) << 31) || q[i] <= -(longint'(1) << 31)) far = 1'b1;
        end
        in_ring = 1'b0;
        if (!far) begin
            for (int i = 0; i < 3; i++) begin
                m = (q[i] < 0) ? longint'(-q[i]) : longint'(q[i]);
                sum = sum + m * m;
            end
            rad = root_floor(sum);
            in_ring = (rad >= r_in) && (rad <= r_out);
            if (in_ring && r_out > r_in) begin
                w = r_out - r_in;
                sig = ((rad - r_in) << 16) / w;
                if (sig > 65536) sig = 65536;
            end
        end
        res.index_out  = p.cell_index;
        res.inside_res = in_ring;
        res.sigma      = sig[16:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cyc);
        err_count++;
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // input side: record accepted points and their predictions
    always @(posedge i_clk) begin
        pt_acc <= pt_if.valid && pt_if.ready;
        if (pt_if.valid && pt_if.ready) ring_expect.push_back(predict_ring(pt_if.data));
    end

    // point driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(pt_if.valid && !pt_acc)) begin
            if (tx_gap > 0) begin
                tx_gap    <= tx_gap - 1;
                pt_if.valid <= 1'b0;
            end else if (pending_pts.size() > 0) begin
                pt_if.data  <= pending_pts.pop_front();
                pt_if.valid <= 1'b1;
                tx_gap      <= no_idle ? 0 : $urandom_range(0, 11);
            end else begin
                pt_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        ring_acc <= ring_if.valid && ring_if.ready;
        if (ring_if.valid && ring_if.ready) begin
            if (ring_expect.size() == 0) begin
                report_mismatch("unexpected item", ring_if.data.index_out, 0);
            end else begin
                amrc_pkg::t_out_item want;
                want = ring_expect.pop_front();
                if (ring_if.data.index_out !== want.index_out)
                    report_mismatch("index_out", ring_if.data.index_out, want.index_out);
                if (ring_if.data.inside_res !== want.inside_res)
                    report_mismatch("inside_res", ring_if.data.inside_res, want.inside_res);
                if (ring_if.data.sigma !== want.sigma)
                    report_mismatch("sigma", ring_if.data.sigma, want.sigma);
            end
        end
    end

    // result receiver with random stalls and the long hold-off
    always @(negedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            ring_if.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            ring_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            ring_if.ready <= 1'b0;
        end else if (ring_acc) begin
            w = no_idle ? 0 : $urandom_range(0, 11);
            rx_wait       <= (w > 0) ? w - 1 : 0;
            ring_if.ready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait       <= rx_wait - 1;
            ring_if.ready <= 1'b0;
        end else begin
            ring_if.ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.data.index <= idx;
        cfg_if.data.data  <= val;
        forever begin
            @(posedge i_clk);
            if (cfg_if.valid && cfg_if.ready) break;
        end
        case (idx)
            amrc_pkg::REG_CENTRE_X: zc_x  = val;
            amrc_pkg::REG_CENTRE_Y: zc_y  = val;
            amrc_pkg::REG_CENTRE_Z: zc_z  = val;
            amrc_pkg::REG_AXIS_X:   ax_x  = val[15:0];
            amrc_pkg::REG_AXIS_Y:   ax_y  = val[15:0];
            amrc_pkg::REG_AXIS_Z:   ax_z  = val[15:0];
            amrc_pkg::REG_INNER:    r_in  = val[30:0];
            amrc_pkg::REG_OUTER:    r_out = val[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_zone(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] axx, logic [31:0] axy, logic [31:0] axz,
                            logic [31:0] ri, logic [31:0] ro);
        write_reg(amrc_pkg::REG_CENTRE_X, cx);
        write_reg(amrc_pkg::REG_CENTRE_Y, cy);
        write_reg(amrc_pkg::REG_CENTRE_Z, cz);
        write_reg(amrc_pkg::REG_AXIS_X, axx);
        write_reg(amrc_pkg::REG_AXIS_Y, axy);
        write_reg(amrc_pkg::REG_AXIS_Z, axz);
        write_reg(amrc_pkg::REG_INNER, ri);
        write_reg(amrc_pkg::REG_OUTER, ro);
        // ignored write; upper bits in the values above are masked
        write_reg(REG_SPARE, $urandom);
    endtask

    task automatic wait_idle();
        while (pending_pts.size() > 0 || pt_if.valid || ring_expect.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic push_pt(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        amrc_pkg::t_in_item it;
        it.cell_index = $urandom;
        it.point_x = px;
        it.point_y = py;
        it.point_z = pz;
        pending_pts.push_back(it);
    endtask

    // centre plus an offset of up to 1.5 times the outer radius on each axis, or noise
    task automatic push_random(int n);
        longint span, off[3];
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                push_pt($urandom, $urandom, $urandom);
            end else begin
                span = longint'(r_out) + longint'(r_out) / 2 + 1;
                for (int i = 0; i < 3; i++)
                    off[i] = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
                push_pt(zc_x + off[0][31:0], zc_y + off[1][31:0], zc_z + off[2][31:0]);
            end
        end
    endtask

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0; cfg_if.data = '0;
        pt_if.valid = 1'b0;  pt_if.data = '0;
        ring_if.ready = 1'b0;
        err_count = 0; cyc = 0; no_idle = 0;
        hold_req = 0; hold_seen = 0; hold_left = 0;
        tx_gap = 0; rx_wait = 0; pt_acc = 0; ring_acc = 0;
        zc_x = 0; zc_y = 0; zc_z = 0;
        ax_x = 0; ax_y = 0; ax_z = 16'd16384;
        r_in = 0; r_out = 31'd65536;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset settings: unit disc around the origin
        push_pt(32'h0, 32'h0, 32'h0);
        pending_pts[0].cell_index = 32'h0;
        push_pt(32'h0001_0000, 32'h0, 32'h7fff_ffff);
        push_pt(32'h0000_8000, 32'h0, 32'h8000_0000);
        push_pt(32'h0, 32'hffff_8000, 32'h1234_5678);
        push_pt(32'h0001_0001, 32'h0, 32'h0);
        push_pt(32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
        push_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        pending_pts[pending_pts.size() - 1].cell_index = 32'hffff_ffff;
        wait_idle();

        // far points: centre at the negative extreme
        set_zone(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 16384,
                 32'h0001_0000, 32'h7fff_ffff);
        push_pt(32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
        push_pt(32'h8000_0000, 32'h8000_0000, 32'h0);
        push_pt(32'h8001_0000, 32'h8000_0000, 32'h7fff_ffff);
        push_random(60);
        wait_idle();

        // zero width, axis along x
        set_zone(32'h0002_0000, 32'hfffe_0000, 32'h0, 16384, 0, 0,
                 32'h0003_0000, 32'h0003_0000);
        push_pt(32'h0002_0000, 32'h0001_0000, 32'h0003_0000);
        push_pt(32'h0009_0000, 32'hfffe_0000, 32'hfffd_0000);
        push_random(70);
        wait_idle();

        // inner above outer, negative axis y
        set_zone(32'h0, 32'h0, 32'h7fff_ffff, 0, 32'hffff_c000, 0,
                 32'h0005_0000, 32'h0002_0000);
        push_pt(32'h0003_0000, 32'h0, 32'h7fff_ffff);
        push_random(60);
        wait_idle();

        // non-unit diagonal axis, no idling on either side
        no_idle = 1;
        set_zone($urandom, $urandom, $urandom, 16'h2d41, 16'h2d41, 16'hd2bf,
                 32'h0000_8000, 32'h0004_0000);
        push_random(120);
        wait_idle();
        no_idle = 0;

        // zero axis, largest radii; receiver holds off while points keep coming
        set_zone(32'h7fff_ffff, 32'h0, 32'h8000_0000, 0, 0, 0,
                 32'h0, 32'hffff_ffff);
        push_random(150);
        no_idle = 1;
        hold_req = hold_req + 1;
        wait_idle();
        no_idle = 0;

        // random zones
        for (int ph = 0; ph < 4; ph++) begin
            logic [31:0] ri, ro;
            ri = $urandom_range(0, 32'h0008_0000);
            ro = ri + $urandom_range(0, 32'h0010_0000);
            set_zone($urandom, $urandom, $urandom,
                     $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                     $urandom_range(0, 32768) - 16384, ri, ro);
            push_random(75);
            wait_idle();
        end

        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/amrc_pkg.sv
rtl/amrc_if.sv
rtl/amrc_div.sv
rtl/amrc_sqrt.sv
rtl/annulus_membership_radial_coord.sv
tb/tb_annulus_membership_radial_coord.sv
